FILE: src/sfp_pkg.sv
`timescale 1ns / 1ps
package sfp_pkg;

   localparam int unsigned CoordW = 24;
   localparam int unsigned SizeW  = 13;
   localparam int unsigned RandW  = 16;
   localparam int unsigned PlotW  = 12;
   localparam int unsigned OpW    = 8;
   localparam int unsigned StatW  = 3;

   localparam logic [StatW-1:0] ST_END   = 3'd0;
   localparam logic [StatW-1:0] ST_PLOT  = 3'd1;
   localparam logic [StatW-1:0] ST_SKIP  = 3'd2;
   localparam logic [StatW-1:0] ST_ADD   = 3'd3;
   localparam logic [StatW-1:0] ST_FULL  = 3'd4;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_DEPTH  = 2'd2;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic [SizeW-1:0]         z;
   } star_type;

   // control to the cell row
   typedef struct packed {
      logic push;   // shift toward higher index, insert at 0
      logic pull;   // shift toward lower index from a point
      logic dec;    // decrement z of the entry in cell 0
      logic rot;    // rotate flag; the cells ignore it (rotation is a push with wrap)
   } row_ctl_type;

endpackage

FILE: src/starfield_perspective_projector_core.sv
`timescale 1ns / 1ps
// Channel   Ports                                   Handshake
// request   req_command, req_random_x/y             start & !busy
// response  rsp_status .. rsp_star_removed          rsp_strobe, one cycle
// config    csr_index, csr_data                     csr_valid & csr_ready
//
// Busy per beat: a full or empty table goes straight to the result; an add runs
// two serial remainders, then the insert; a star that reached the viewer is
// rotated to cell 0, rotated back and removed; plot or off-screen: rotate to
// cell 0, x/z and y/z divides in parallel, then the opacity divide, rotate back.
// Entry 0 needs no rotation. The result strobes in the cycle busy drops, when a
// new start may already be taken. Reset is synchronous, clears control state only.
module starfield_perspective_projector_core #(
   parameter int unsigned MAX_POINTS     = 64,
   parameter int unsigned OPACITY_LEVELS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [15:0] req_random_x,
   input  logic [15:0] req_random_y,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic        rsp_point_valid,
   output logic signed [11:0] rsp_plot_x,
   output logic signed [11:0] rsp_plot_y,
   output logic [7:0]  rsp_opacity,
   output logic        rsp_star_removed,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   localparam int unsigned IW = $clog2(MAX_POINTS + 1);
   localparam int unsigned LW = $clog2(OPACITY_LEVELS + 1);
   localparam int unsigned NW = LW + 2 + sfp_pkg::SizeW + 1;
   localparam int unsigned RW = IW > 6 ? IW : 6;

   typedef enum logic [3:0] {
      S_IDLE, S_SPAWN, S_SPAWN2, S_ADD, S_ROT, S_DIV1, S_DIV2,
      S_MOVE, S_DONE
   } state_type;

   state_type state_ff;
   logic [12:0] width_ff, height_ff, depth_ff;
   logic [IW-1:0] count_ff, cursor_ff;
   logic [RW-1:0] rot_ff;
   logic [IW-1:0] idx_ff;
   logic          remove_ff;
   logic          strobe_ff;
   logic [2:0]    status_ff;
   logic          valid_ff, removed_ff;
   logic signed [11:0] px_ff, py_ff;
   logic [7:0]    op_ff;
   logic signed [sfp_pkg::CoordW-1:0] sx_ff, sy_ff;
   logic [15:0]   ry_ff;
   logic signed [sfp_pkg::CoordW-1:0] qx_ff, qy_ff;

   // row
   sfp_pkg::row_ctl_type ctl;
   sfp_pkg::star_type cq [MAX_POINTS];
   sfp_pkg::star_type new_star;
   logic [MAX_POINTS-1:0] pull_mask;

   assign new_star.x = sx_ff;
   assign new_star.y = sy_ff;
   assign new_star.z = depth_ff;

   // rotation: push with cell 0 fed by last cell, wrap of whole row
   logic rot_mode;
   sfp_pkg::star_type head_in;
   assign head_in = rot_mode ? cq[MAX_POINTS-1] : new_star;

   for (genvar g = 0; g < MAX_POINTS; g++) begin : g_row
      sfp_pkg::star_type fp, fn;
      assign fp = (g == 0) ? head_in : cq[(g == 0) ? 0 : g - 1];
      assign fn = (g == MAX_POINTS - 1) ? cq[0] : cq[(g == MAX_POINTS - 1) ? 0 : g + 1];
      sfp_cell u_cell (
         .clock(clock), .ctl(ctl), .pull_here(pull_mask[g]),
         .dec_here(g == 0), .from_prev(fp), .from_next(fn), .q(cq[g])
      );
   end

   // spawn arithmetic: modulo by repeated subtraction is too slow; use a
   // 16-step serial remainder shared by x and y over the spawn states
   logic [4:0]  mcnt_ff;
   logic [13:0] mr_ff;
   logic [15:0] mq_ff;
   logic [12:0] msize;
   logic [13:0] mtrial;
   logic signed [13:0] moff;
   logic signed [27:0] mprod;
   assign msize  = (state_ff == S_SPAWN) ? width_ff : height_ff;
   assign mtrial = {mr_ff[12:0], mq_ff[15]};
   assign moff   = $signed({1'b0, mr_ff[12:0]}) - $signed({2'b0, msize[12:1]});
   assign mprod  = moff * $signed({1'b0, depth_ff});

   // dividers
   logic dstart, dxd, dyd, dod;
   logic signed [sfp_pkg::CoordW-1:0] dxq, dyq;
   logic signed [NW-1:0] onum, oq;
   logic [12:0] oden;
   sfp_divider #(.NW(sfp_pkg::CoordW), .DW(sfp_pkg::SizeW)) u_dx (
      .clock, .reset, .start(dstart), .num(cq[0].x), .den(cq[0].z),
      .done(dxd), .quot(dxq));
   sfp_divider #(.NW(sfp_pkg::CoordW), .DW(sfp_pkg::SizeW)) u_dy (
      .clock, .reset, .start(dstart), .num(cq[0].y), .den(cq[0].z),
      .done(dyd), .quot(dyq));
   logic ostart;
   sfp_divider #(.NW(NW), .DW(sfp_pkg::SizeW)) u_op (
      .clock, .reset, .start(ostart), .num(onum), .den(oden),
      .done(dod), .quot(oq));

   logic signed [sfp_pkg::SizeW+1:0] zdiff;
   assign zdiff = $signed({2'b00, depth_ff}) - $signed({2'b00, cq[0].z});
   assign onum  = $signed(NW'(zdiff)) * $signed(NW'(OPACITY_LEVELS * 4));
   assign oden  = depth_ff;

   logic [sfp_pkg::CoordW-1:0] ax, ay;
   assign ax = qx_ff[sfp_pkg::CoordW-1] ? -qx_ff : qx_ff;
   assign ay = qy_ff[sfp_pkg::CoordW-1] ? -qy_ff : qy_ff;
   logic offs;
   assign offs = (ax >= sfp_pkg::CoordW'(width_ff[12:1])) ||
                 (ay >= sfp_pkg::CoordW'(height_ff[12:1]));

   logic accept;
   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);

   // entry visited by a process beat
   logic [IW-1:0] pick;
   assign pick = (cursor_ff == '0 || cursor_ff > count_ff) ? '0 : cursor_ff - 1'b1;

   always_comb begin
      ctl = '0; rot_mode = 1'b0; pull_mask = '0;
      dstart = 1'b0; ostart = 1'b0;
      unique case (state_ff)
         S_ADD: ctl.push = 1'b1;
         S_ROT: if (rot_ff != '0) begin ctl.push = 1'b1; rot_mode = 1'b1; end
         else dstart = (cq[0].z != '0);
         S_DIV1: ostart = dxd;
         S_DIV2: ctl.dec = dod && !offs;
         S_MOVE: if (rot_ff != '0) begin
            // undo rotation
            ctl.push = 1'b1; rot_mode = 1'b1;
         end else if (remove_ff) begin
            // close the gap: cells from idx on take their neighbor
            ctl.pull = 1'b1;
            for (int k = 0; k < MAX_POINTS; k++) pull_mask[k] = (IW'(k) >= idx_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; width_ff <= 13'd640; height_ff <= 13'd480;
         depth_ff <= 13'd256; count_ff <= '0; cursor_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               sfp_pkg::CSR_WIDTH:  width_ff  <= csr_data;
               sfp_pkg::CSR_HEIGHT: height_ff <= csr_data;
               sfp_pkg::CSR_DEPTH:  depth_ff  <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: if (accept) begin
               valid_ff <= 1'b0; removed_ff <= 1'b0; px_ff <= '0; py_ff <= '0;
               op_ff <= '0;
               if (!req_command) begin
                  if (count_ff >= IW'(MAX_POINTS)) begin
                     status_ff <= sfp_pkg::ST_FULL; state_ff <= S_DONE;
                  end else begin
                     ry_ff <= req_random_y;
                     mq_ff <= req_random_x; mr_ff <= '0; mcnt_ff <= 5'd16;
                     state_ff <= S_SPAWN;
                  end
               end else if (cursor_ff == '0 && count_ff == '0) begin
                  status_ff <= sfp_pkg::ST_END; state_ff <= S_DONE;
               end else begin
                  // pick visited entry, rotate it to cell 0
                  idx_ff <= pick;
                  rot_ff <= (pick == '0) ? '0 : RW'(MAX_POINTS) - RW'(pick);
                  state_ff <= S_ROT;
               end
            end
            S_SPAWN, S_SPAWN2: begin
               if (mcnt_ff != '0) begin
                  if (msize != '0 && mtrial >= {1'b0, msize}) begin
                     mr_ff <= mtrial - {1'b0, msize};
                  end else begin
                     mr_ff <= mtrial;
                  end
                  mq_ff <= {mq_ff[14:0], 1'b0};
                  mcnt_ff <= mcnt_ff - 1'b1;
               end else begin
                  if (state_ff == S_SPAWN) begin
                     sx_ff <= (msize == '0) ? '0 : mprod[sfp_pkg::CoordW-1:0];
                     mq_ff <= ry_ff; mr_ff <= '0; mcnt_ff <= 5'd16;
                     state_ff <= S_SPAWN2;
                  end else begin
                     sy_ff <= (msize == '0) ? '0 : mprod[sfp_pkg::CoordW-1:0];
                     state_ff <= S_ADD;
                  end
               end
            end
            S_ADD: begin
               count_ff <= count_ff + 1'b1;
               if (cursor_ff != '0) cursor_ff <= cursor_ff + 1'b1;
               status_ff <= sfp_pkg::ST_ADD; state_ff <= S_DONE;
            end
            S_ROT: if (rot_ff != '0 && rot_ff != RW'(MAX_POINTS)) begin
               rot_ff <= rot_ff - 1'b1;
            end else if (cq[0].z == '0) begin
               remove_ff <= 1'b1; removed_ff <= 1'b1;
               status_ff <= sfp_pkg::ST_SKIP;
               cursor_ff <= (IW'(idx_ff) + 1'b1 >= count_ff) ? '0 : idx_ff + 1'b1;
               state_ff <= S_MOVE; rot_ff <= RW'(idx_ff);
            end else begin
               state_ff <= S_DIV1;
            end
            S_DIV1: if (dxd) begin
               qx_ff <= dxq; qy_ff <= dyq; state_ff <= S_DIV2;
            end
            S_DIV2: if (dod) begin
               rot_ff <= RW'(idx_ff);
               if (offs) begin
                  remove_ff <= 1'b1; removed_ff <= 1'b1;
                  if (IW'(idx_ff) + 1'b1 >= count_ff) begin
                     cursor_ff <= '0; status_ff <= sfp_pkg::ST_END;
                  end else begin
                     cursor_ff <= idx_ff + 1'b1; status_ff <= sfp_pkg::ST_SKIP;
                  end
               end else begin
                  remove_ff <= 1'b0; valid_ff <= 1'b1;
                  px_ff <= qx_ff[11:0]; py_ff <= qy_ff[11:0];
                  if (depth_ff == '0 || zdiff <= 0) op_ff <= '0;
                  else if (oq >= NW'(OPACITY_LEVELS - 1) || oq > NW'(255))
                     op_ff <= (OPACITY_LEVELS - 1 > 255) ? 8'd255
                              : 8'(OPACITY_LEVELS - 1);
                  else op_ff <= oq[7:0];
                  if (IW'(idx_ff) + 1'b1 < count_ff) begin
                     cursor_ff <= idx_ff + 2'd2; status_ff <= sfp_pkg::ST_PLOT;
                  end else begin
                     cursor_ff <= '0; status_ff <= sfp_pkg::ST_END;
                  end
               end
               state_ff <= S_MOVE;
            end
            S_MOVE: begin
               if (rot_ff != '0) rot_ff <= rot_ff - 1'b1;
               else begin
                  if (remove_ff) count_ff <= count_ff - 1'b1;
                  remove_ff <= 1'b0;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               strobe_ff <= 1'b1; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_point_valid  = valid_ff;
   assign rsp_plot_x       = px_ff;
   assign rsp_plot_y       = py_ff;
   assign rsp_opacity      = op_ff;
   assign rsp_star_removed = removed_ff;

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IW'(MAX_POINTS)) else $error("star count overflow");
   a_cursor: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= count_ff + 1'b1) else $error("cursor past table");
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("strobe while busy");
`endif
endmodule

FILE: src/sfp_cell.sv
`timescale 1ns / 1ps
module sfp_cell (
   input  logic                clock,
   input  sfp_pkg::row_ctl_type ctl,
   input  logic                pull_here,  // this cell at or behind the removal point
   input  logic                dec_here,
   input  sfp_pkg::star_type   from_prev,
   input  sfp_pkg::star_type   from_next,
   output sfp_pkg::star_type   q
);
   sfp_pkg::star_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.push) begin
         data_in = from_prev;
      end else if (ctl.pull && pull_here) begin
         data_in = from_next;
      end else if (ctl.dec && dec_here) begin
         data_in.z = data_ff.z - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;
endmodule

FILE: src/sfp_divider.sv
`timescale 1ns / 1ps
// Signed restoring divider, one quotient bit a cycle, truncates toward zero.
module sfp_divider #(
   parameter int unsigned NW = 24,
   parameter int unsigned DW = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] num,
   input  logic [DW-1:0]        den,
   output logic                 done,
   output logic signed [NW-1:0] quot
);
   localparam int unsigned CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial;
   logic [NW-1:0] mag;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      mag = num[NW-1] ? (~num + 1'b1) : num;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = mag; r_in = '0; d_in = den; neg_in = num[NW-1];
         cnt_in = CW'(NW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? $signed(~q_ff + 1'b1) : $signed(q_ff);
endmodule
